[sv/slid_pkg.sv]
package slid_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W  = 32;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [4:0]                entry_count;
    logic                      head_valid;
    logic signed [VALUE_W-1:0] smallest_value;
  } out_item_t;

  // broadcast to every cell for one operation
  typedef struct packed {
    logic                      wr;
    logic                      del;
    logic                      found;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

[sv/slid_cell.sv]
module slid_cell (
  input  logic                                clk_i,
  input  slid_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                occupied_i,
  input  logic                                left_lt_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] left_entry_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] right_entry_i,
  output logic                                lt_o,
  output logic                                eq_o,
  output logic signed [slid_pkg::VALUE_W-1:0] entry_o,
  output logic signed [slid_pkg::VALUE_W-1:0] entry_d_o
);

  logic signed [slid_pkg::VALUE_W-1:0] entry_q, entry_d;

  assign lt_o = occupied_i && (entry_q < ctrl_i.value);
  assign eq_o = occupied_i && (entry_q == ctrl_i.value);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.wr) begin
      if (ctrl_i.del) begin
        if (ctrl_i.found && !lt_o) begin
          entry_d = right_entry_i;
        end
      end else if (!lt_o) begin
        entry_d = left_lt_i ? ctrl_i.value : left_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

[sv/sorted_list_insert_delete_top.sv]
// Sorted insertion list: up to CAPACITY signed 32-bit values kept ascending
// in a row of compare cells.
// Input channel in_valid_i/in_stall_o carries mode (insert or delete) and a
// value; a transfer happens when valid is high and stall is low.
// Output channel out_valid_o/out_stall_i returns one result per item:
// status, entry count, head valid flag and the smallest stored value.
// Every cell compares its entry to the broadcast value in the same cycle and
// shifts left or right, so an item finishes in the cycle it is accepted.
// out_valid_o rises in the cycle after the input transfer.
// Throughput is one item per cycle while the receiver does not stall; the
// single output register sets that figure.
// While a result waits under out_stall_i, in_stall_o is high and nothing new
// is accepted; the pending result holds steady.
// Reset empties the list (count to zero) and clears out_valid_o;
// there is no clearing pass, entries beyond the count are never read.
module sorted_list_insert_delete_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slid_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output slid_pkg::out_item_t out_data_o
);

  localparam int unsigned N = slid_pkg::CAPACITY;

  logic [slid_pkg::COUNT_W-1:0] count_q, count_d;
  logic                         out_valid_q, out_valid_d;
  slid_pkg::out_item_t          out_data_q, out_data_d;

  logic                                in_xfer, full, found, is_del;
  logic [N-1:0]                        lt, eq;
  logic signed [slid_pkg::VALUE_W-1:0] entry [N];
  logic signed [slid_pkg::VALUE_W-1:0] entry_d [N];
  slid_pkg::cell_ctrl_t                ctrl;
  slid_pkg::status_e                   status;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign is_del     = (in_data_i.mode == slid_pkg::MODE_DELETE);
  assign full       = (count_q == slid_pkg::COUNT_W'(N));
  assign found      = |eq;

  always_comb begin
    ctrl.del   = is_del;
    ctrl.found = found;
    ctrl.value = in_data_i.value;
    ctrl.wr    = in_xfer && (is_del ? found : !full);
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                                left_lt;
    logic signed [slid_pkg::VALUE_W-1:0] left_entry, right_entry;
    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = entry[0];
    end else begin : g_mid
      assign left_lt    = lt[i-1];
      assign left_entry = entry[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end
    slid_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (slid_pkg::COUNT_W'(i) < count_q),
      .left_lt_i    (left_lt),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .lt_o         (lt[i]),
      .eq_o         (eq[i]),
      .entry_o      (entry[i]),
      .entry_d_o    (entry_d[i])
    );
  end

  always_comb begin
    count_d = count_q;
    status  = slid_pkg::STATUS_DONE;
    if (is_del) begin
      if (found) begin
        count_d = count_q - slid_pkg::COUNT_W'(1);
      end else begin
        status = slid_pkg::STATUS_NOT_FOUND;
      end
    end else if (full) begin
      status = slid_pkg::STATUS_FULL;
    end else begin
      count_d = count_q + slid_pkg::COUNT_W'(1);
    end
    if (!in_xfer) begin
      count_d = count_q;
    end

    out_data_d.status         = status;
    out_data_d.entry_count    = 5'(count_d);
    out_data_d.head_valid     = (count_d != '0);
    out_data_d.smallest_value = (count_d != '0) ? entry_d[0] : '0;

    out_valid_d = out_valid_q && out_stall_i;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= slid_pkg::COUNT_W'(N))
    else $error("entry count above capacity");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("accepted item produced no result");

  a_count_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(count_q))
    else $error("count changed without a transfer");

  a_head_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (out_data_q.head_valid == (count_q != '0)))
    else $error("head flag disagrees with count");
`endif

endmodule
